// ===== hw/rtl/aod_pkg.sv =====
// ----------------------------------------------------------------------------
// aod_pkg
// Shared constants, beat types and helpers for the audio peak / onset / click
// detector.
// ----------------------------------------------------------------------------
package aod_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_BITS  = 24;
    localparam int MAG_W        = SAMPLE_BITS - 1;
    localparam int CC_W         = 4;
    localparam int THR_W        = 24;
    localparam int IDX_W        = 32;
    localparam int CFG_W        = 24;
    localparam int CFG_ADDR_W   = 2;
    // frame position storage width (the position+1 compare uses CNT_W)
    localparam int POS_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);

    localparam logic [CFG_ADDR_W-1:0] REG_CHAN_COUNT  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_SILENCE_THR = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_CLICK_THR   = CFG_ADDR_W'(2);

    localparam logic [CC_W-1:0]  CHAN_COUNT_RST  = CC_W'(2);
    localparam logic [THR_W-1:0] SILENCE_THR_RST = THR_W'(0);
    localparam logic [THR_W-1:0] CLICK_THR_RST   = THR_W'(24'h80_0000);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_value;
        logic                          restart;
    } sample_beat_t;

    typedef struct packed {
        logic [IDX_W-1:0] frame_index;
        logic [MAG_W-1:0] peak_in_frame;
        logic [MAG_W-1:0] overall_peak;
        logic             onset_found;
        logic [IDX_W-1:0] onset_at_frame;
        logic             click_seen;
    } result_beat_t;

    // |x|, with the most negative code clamped to the largest positive value
    function automatic logic [MAG_W-1:0] magnitude(input logic [SAMPLE_BITS-1:0] s);
        logic [SAMPLE_BITS-1:0] neg;
        logic [MAG_W-1:0]       m;
        neg = (~s) + SAMPLE_BITS'(1);
        if (!s[SAMPLE_BITS-1])
            m = s[MAG_W-1:0];
        else if (neg[SAMPLE_BITS-1])
            m = '1;
        else
            m = neg[MAG_W-1:0];
        return m;
    endfunction

endpackage

// ===== hw/rtl/aod_intf.sv =====
// ----------------------------------------------------------------------------
// aod stream interfaces
// Valid/ready channels for sample beats in and analysis beats out.
// ----------------------------------------------------------------------------
interface aod_sample_if
    import aod_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          restart;

    modport source (output valid, output sample_value, output restart, input ready);
    modport sink   (input valid, input sample_value, input restart, output ready);
endinterface

interface aod_result_if
    import aod_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] frame_index;
    logic [MAG_W-1:0] peak_in_frame;
    logic [MAG_W-1:0] overall_peak;
    logic             onset_found;
    logic [IDX_W-1:0] onset_at_frame;
    logic             click_seen;

    modport source (output valid, output frame_index, output peak_in_frame,
                    output overall_peak, output onset_found, output onset_at_frame,
                    output click_seen, input ready);
    modport sink   (input valid, input frame_index, input peak_in_frame,
                    input overall_peak, input onset_found, input onset_at_frame,
                    input click_seen, output ready);
endinterface

// ===== hw/rtl/aod_in_stage.sv =====
// ----------------------------------------------------------------------------
// aod_in_stage
// Input register: captures one sample beat and holds it until the analysis
// stage consumes it.
// ----------------------------------------------------------------------------
module aod_in_stage
    import aod_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  sample_beat_t in_beat,
    output logic         in_ready,
    output logic         out_valid,
    output sample_beat_t out_beat,
    input  logic         advance
);

    logic         valid_reg;
    sample_beat_t beat_reg;

    assign in_ready  = !valid_reg || advance;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= in_beat;
        end
    end

endmodule

// ===== hw/rtl/aod_core.sv =====
// ----------------------------------------------------------------------------
// aod_core
// Config registers, running analysis state and the result register. One
// sample beat is folded into the state per cycle while the result is not stalled.
// ----------------------------------------------------------------------------
module aod_core
    import aod_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_valid,
    input  sample_beat_t          s_beat,
    output logic                  s_advance,
    output logic                  res_valid,
    output result_beat_t          res_beat,
    input  logic                  res_ready
);

    logic [CC_W-1:0]  cc_reg;
    logic [THR_W-1:0] sil_thr_reg;
    logic [THR_W-1:0] clk_thr_reg;

    logic [POS_W-1:0] pos_reg,  pos_next;
    logic [MAG_W-1:0] cfp_reg,  cfp_next;
    logic [MAG_W-1:0] pfp_reg,  pfp_next;
    logic [MAG_W-1:0] pso_reg,  pso_next;
    logic             ov_reg,   ov_next;
    logic [IDX_W-1:0] oi_reg,   oi_next;
    logic             click_reg, click_next;
    logic [IDX_W-1:0] fc_reg,   fc_next;

    logic             out_valid_reg, out_valid_next;
    result_beat_t     out_beat_reg,  out_beat_next;

    logic             fire;
    logic [CNT_W-1:0] eff;
    logic [CNT_W-1:0] pos_inc;
    logic             done;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] cfp_b, pfp_b, pso_b, cfp_new, pso_new, diff;
    logic [IDX_W-1:0] oi_b, fc_b;
    logic             ov_b, click_b, onset_hit, click_hit;

    assign s_advance = !out_valid_reg || res_ready;
    assign fire      = s_valid && s_advance;
    assign res_valid = out_valid_reg;
    assign res_beat  = out_beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg      <= CHAN_COUNT_RST;
            sil_thr_reg <= SILENCE_THR_RST;
            clk_thr_reg <= CLICK_THR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CHAN_COUNT:  cc_reg      <= cfg_data[CC_W-1:0];
                REG_SILENCE_THR: sil_thr_reg <= cfg_data[THR_W-1:0];
                REG_CLICK_THR:   clk_thr_reg <= cfg_data[THR_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (cc_reg == '0)
            eff = CNT_W'(1);
        else if (int'(cc_reg) > MAX_CHANNELS)
            eff = CNT_W'(MAX_CHANNELS);
        else
            eff = CNT_W'(cc_reg);
    end

    always_comb
    begin
        // restart clears the state ahead of this sample
        cfp_b   = s_beat.restart ? '0   : cfp_reg;
        pfp_b   = s_beat.restart ? '0   : pfp_reg;
        pso_b   = s_beat.restart ? '0   : pso_reg;
        ov_b    = s_beat.restart ? 1'b0 : ov_reg;
        oi_b    = s_beat.restart ? '0   : oi_reg;
        click_b = s_beat.restart ? 1'b0 : click_reg;
        fc_b    = s_beat.restart ? '0   : fc_reg;
        pos_inc = (s_beat.restart ? CNT_W'(0) : CNT_W'(pos_reg)) + CNT_W'(1);

        mag     = magnitude(s_beat.sample_value);
        cfp_new = (mag > cfp_b) ? mag : cfp_b;
        pso_new = (mag > pso_b) ? mag : pso_b;
        done    = (pos_inc >= eff);

        onset_hit = !ov_b && ({1'b0, cfp_new} >= sil_thr_reg);
        diff      = (cfp_new >= pfp_b) ? (cfp_new - pfp_b) : (pfp_b - cfp_new);
        click_hit = (fc_b != '0) && ({1'b0, diff} >= clk_thr_reg);

        pos_next   = pos_reg;
        cfp_next   = cfp_reg;
        pfp_next   = pfp_reg;
        pso_next   = pso_reg;
        ov_next    = ov_reg;
        oi_next    = oi_reg;
        click_next = click_reg;
        fc_next    = fc_reg;

        out_valid_next = res_ready ? 1'b0 : out_valid_reg;
        out_beat_next  = out_beat_reg;

        if (fire)
        begin
            pso_next   = pso_new;
            pfp_next   = pfp_b;
            ov_next    = ov_b;
            oi_next    = oi_b;
            click_next = click_b;
            fc_next    = fc_b;
            if (!done)
            begin
                pos_next = pos_inc[POS_W-1:0];
                cfp_next = cfp_new;
            end
            else
            begin
                pos_next = '0;
                cfp_next = '0;
                pfp_next = cfp_new;
                if (onset_hit)
                begin
                    ov_next = 1'b1;
                    oi_next = fc_b;
                end
                if (click_hit)
                    click_next = 1'b1;
                if (fc_b != '1)
                    fc_next = fc_b + IDX_W'(1);

                out_valid_next               = 1'b1;
                out_beat_next.frame_index    = fc_b;
                out_beat_next.peak_in_frame  = cfp_new;
                out_beat_next.overall_peak   = pso_new;
                out_beat_next.onset_found    = ov_b || onset_hit;
                out_beat_next.onset_at_frame = onset_hit ? fc_b : oi_b;
                out_beat_next.click_seen     = click_b || click_hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            cfp_reg       <= '0;
            pfp_reg       <= '0;
            pso_reg       <= '0;
            ov_reg        <= 1'b0;
            oi_reg        <= '0;
            click_reg     <= 1'b0;
            fc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            cfp_reg       <= cfp_next;
            pfp_reg       <= pfp_next;
            pso_reg       <= pso_next;
            ov_reg        <= ov_next;
            oi_reg        <= oi_next;
            click_reg     <= click_next;
            fc_reg        <= fc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_beat_reg <= out_beat_next;
    end

endmodule

// ===== hw/rtl/audio_peak_onset_click_detector.sv =====
// Audio peak / onset / click detector. Interleaved signed 24-bit samples come in
// on the sample channel, one beat per cycle at full rate; every channel-count
// samples form a frame, and the beat that closes a frame produces one analysis
// beat (frame peak, overall peak, onset and sticky click flag) on the result
// channel. The closing sample is first held in the input register, then the
// analysis logic loads the result register and raises result valid. A stalled
// result holds off the sample channel. Restart on a sample clears the running
// state before that sample is used. Config writes are meant for idle periods
// only.
// ----------------------------------------------------------------------------
// audio_peak_onset_click_detector
// Top level: input register stage plus analysis core.
// ----------------------------------------------------------------------------
module audio_peak_onset_click_detector
    import aod_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    aod_sample_if.sink            samples,
    aod_result_if.source          results
);

    sample_beat_t in_beat;
    sample_beat_t s_beat;
    result_beat_t r_beat;
    logic         s_valid;
    logic         s_advance;

    assign in_beat.sample_value = samples.sample_value;
    assign in_beat.restart      = samples.restart;

    aod_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_beat   (in_beat),
        .in_ready  (samples.ready),
        .out_valid (s_valid),
        .out_beat  (s_beat),
        .advance   (s_advance)
    );

    aod_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_beat    (s_beat),
        .s_advance (s_advance),
        .res_valid (results.valid),
        .res_beat  (r_beat),
        .res_ready (results.ready)
    );

    assign results.frame_index    = r_beat.frame_index;
    assign results.peak_in_frame  = r_beat.peak_in_frame;
    assign results.overall_peak   = r_beat.overall_peak;
    assign results.onset_found    = r_beat.onset_found;
    assign results.onset_at_frame = r_beat.onset_at_frame;
    assign results.click_seen     = r_beat.click_seen;

endmodule

// ===== hw/rtl/aod_checker.sv =====
// ----------------------------------------------------------------------------
// aod_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module aod_checker
    import aod_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [IDX_W-1:0] frame_index,
    input logic [MAG_W-1:0] peak_in_frame,
    input logic [MAG_W-1:0] overall_peak,
    input logic             onset_found,
    input logic [IDX_W-1:0] onset_at_frame,
    input logic             click_seen
);

    // stalled result beat keeps valid, frame index, frame peak and onset frame
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_index)
            && $stable(peak_in_frame) && $stable(onset_at_frame))
        else $error("result beat changed while stalled");

    a_peak_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> peak_in_frame <= overall_peak)
        else $error("frame peak above overall peak");

    a_onset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !onset_found |-> onset_at_frame == '0)
        else $error("onset frame set without onset");

    a_onset_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && onset_found |-> onset_at_frame <= frame_index)
        else $error("onset frame after current frame");

    // first frame after restart is exempt from the click test
    a_click_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && click_seen |-> frame_index != '0)
        else $error("click flagged on first frame");

endmodule

bind audio_peak_onset_click_detector aod_checker u_aod_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .frame_index    (results.frame_index),
    .peak_in_frame  (results.peak_in_frame),
    .overall_peak   (results.overall_peak),
    .onset_found    (results.onset_found),
    .onset_at_frame (results.onset_at_frame),
    .click_seen     (results.click_seen)
);

// ===== bench/audio_peak_onset_click_detector_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// audio_peak_onset_click_detector_test
// Self-checking bench for the peak / onset / click detector. Sample beats are
// sent with random gaps and the result channel is stalled at random. A local
// frame analyzer predicts each result beat from the accepted samples and the
// register settings, and every result is compared field by field. Directed
// frames hit the magnitude extremes, restart, threshold limits and channel
// counts out of range; random phases then rerun the analysis under varied
// settings.
// ----------------------------------------------------------------------------
module audio_peak_onset_click_detector_test;
    import aod_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_GAP        = 13;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    aod_sample_if sample_ch ();
    aod_result_if result_ch ();

    audio_peak_onset_click_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (sample_ch),
        .results   (result_ch)
    );

    always #5 clk = ~clk;

    // register copies
    logic [CC_W-1:0]  frame_channels = CHAN_COUNT_RST;
    logic [THR_W-1:0] silence_level  = SILENCE_THR_RST;
    logic [THR_W-1:0] click_level    = CLICK_THR_RST;

    // running analysis
    int               frame_fill     = 0;
    logic [MAG_W-1:0] frame_max      = '0;
    logic [MAG_W-1:0] last_frame_max = '0;
    logic [MAG_W-1:0] dump_max       = '0;
    logic             onset_seen     = 1'b0;
    logic [IDX_W-1:0] onset_at       = '0;
    logic             click_latched  = 1'b0;
    logic [IDX_W-1:0] frames_done    = '0;

    sample_beat_t pending_samples[$];
    result_beat_t expected_frames[$];

    int send_gap        = 0;
    int result_stall    = 0;
    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;
    int failures        = 0;
    int quiet_cycles    = 0;
    int unsigned phase_level;

    function automatic void analyze_sample(input logic signed [SAMPLE_BITS-1:0] value,
                                           input logic restart);
        logic [MAG_W-1:0]       mag;
        logic [MAG_W-1:0]       jump;
        logic [SAMPLE_BITS-1:0] flipped;
        int                     frame_len;
        result_beat_t           beat;
        if (restart)
        begin
            frame_fill     = 0;
            frame_max      = '0;
            last_frame_max = '0;
            dump_max       = '0;
            onset_seen     = 1'b0;
            onset_at       = '0;
            click_latched  = 1'b0;
            frames_done    = '0;
        end
        flipped = -value;
        if (!value[SAMPLE_BITS-1])
            mag = value[MAG_W-1:0];
        else if (value[MAG_W-1:0] == '0)
            mag = '1;   // most negative code clamps
        else
            mag = flipped[MAG_W-1:0];
        if (mag > frame_max)
            frame_max = mag;
        if (mag > dump_max)
            dump_max = mag;

        frame_len = (frame_channels == 0) ? 1
                  : (frame_channels > MAX_CHANNELS) ? MAX_CHANNELS : int'(frame_channels);
        frame_fill++;
        if (frame_fill < frame_len)
            return;

        if (!onset_seen && {1'b0, frame_max} >= silence_level)
        begin
            onset_seen = 1'b1;
            onset_at   = frames_done;
        end
        jump = (frame_max >= last_frame_max) ? frame_max - last_frame_max
                                             : last_frame_max - frame_max;
        if (frames_done != 0 && {1'b0, jump} >= click_level)
            click_latched = 1'b1;

        beat.frame_index    = frames_done;
        beat.peak_in_frame  = frame_max;
        beat.overall_peak   = dump_max;
        beat.onset_found    = onset_seen;
        beat.onset_at_frame = onset_seen ? onset_at : '0;
        beat.click_seen     = click_latched;
        expected_frames.push_back(beat);

        last_frame_max = frame_max;
        frame_max      = '0;
        frame_fill     = 0;
        if (frames_done != '1)
            frames_done++;
    endfunction

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        sample_beat_t beat;
        if (!rst_n)
        begin
            sample_ch.valid        <= 1'b0;
            sample_ch.sample_value <= '0;
            sample_ch.restart      <= 1'b0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
                analyze_sample(sample_ch.sample_value, sample_ch.restart);
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (send_gap > 0 || pending_samples.size() == 0)
                begin
                    if (send_gap > 0)
                        send_gap--;
                    sample_ch.valid <= 1'b0;
                end
                else
                begin
                    beat = pending_samples.pop_front();
                    sample_ch.valid        <= 1'b1;
                    sample_ch.sample_value <= beat.sample_value;
                    sample_ch.restart      <= beat.restart;
                    if ($urandom_range(0, 19) == 0)
                        sender_steady = !sender_steady;
                    send_gap = sender_steady ? 0 : $urandom_range(0, MAX_GAP);
                end
            end
        end
    end

    task automatic check_field(input string field, input logic [IDX_W-1:0] want,
                               input logic [IDX_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endtask

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        result_beat_t want;
        logic         next_ready;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    $error("result beat with none expected, frame_index %0d",
                           result_ch.frame_index);
                    failures++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    check_field("frame_index", want.frame_index, result_ch.frame_index);
                    check_field("peak_in_frame", IDX_W'(want.peak_in_frame),
                                IDX_W'(result_ch.peak_in_frame));
                    check_field("overall_peak", IDX_W'(want.overall_peak),
                                IDX_W'(result_ch.overall_peak));
                    check_field("onset_found", IDX_W'(want.onset_found),
                                IDX_W'(result_ch.onset_found));
                    check_field("onset_at_frame", want.onset_at_frame,
                                result_ch.onset_at_frame);
                    check_field("click_seen", IDX_W'(want.click_seen),
                                IDX_W'(result_ch.click_seen));
                end
                if ($urandom_range(0, 19) == 0)
                    receiver_steady = !receiver_steady;
                result_stall = receiver_steady ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (result_stall > 0)
            begin
                result_stall--;
                next_ready = 1'b0;
            end
            else
            begin
                next_ready = 1'b1;
            end
            result_ch.ready <= next_ready;
        end
    end

    // watchdog: no beat on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_register(input logic [CFG_ADDR_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            REG_CHAN_COUNT:  frame_channels = value[CC_W-1:0];
            REG_SILENCE_THR: silence_level  = value[THR_W-1:0];
            REG_CLICK_THR:   click_level    = value[THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CFG_W-1:0] channels,
                             input logic [THR_W-1:0] silence, input logic [THR_W-1:0] click);
        write_register(REG_CHAN_COUNT, channels);
        write_register(REG_SILENCE_THR, silence);
        write_register(REG_CLICK_THR, click);
    endtask

    // wait until every sample is taken and every result has arrived
    task automatic settle(input int tail_cycles);
        @(negedge clk);
        while (pending_samples.size() != 0 || sample_ch.valid || expected_frames.size() != 0)
            @(negedge clk);
        repeat (tail_cycles) @(posedge clk);
    endtask

    task automatic queue_sample(input logic [SAMPLE_BITS-1:0] value, input logic restart);
        sample_beat_t beat;
        beat.sample_value = value;
        beat.restart      = restart;
        pending_samples.push_back(beat);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] draw_sample(input int unsigned level);
        logic [SAMPLE_BITS-1:0] mag;
        case ($urandom_range(0, 15))
            0: return 24'h80_0000;
            1: return 24'h7F_FFFF;
            2: return '0;
            3: return SAMPLE_BITS'($urandom);
            default:
            begin
                // quiet samples now and then so peaks jump around
                mag = SAMPLE_BITS'($urandom_range(0, $urandom_range(0, 3) == 0 ? level >> 6
                                                                               : level));
                return $urandom_range(0, 1) ? -mag : mag;
            end
        endcase
    endfunction

    function automatic logic [THR_W-1:0] draw_threshold(input int unsigned level);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 24'h80_0000;
            2: return 24'hFF_FFFF;
            3: return THR_W'($urandom);
            default: return THR_W'($urandom_range(0, level));
        endcase
    endfunction

    task automatic queue_random(input int count, input bit open_restart);
        @(negedge clk);
        for (int i = 0; i < count; i++)
            queue_sample(draw_sample(phase_level),
                         (i == 0 && open_restart) || $urandom_range(0, 29) == 0);
    endtask

    initial
    begin
        logic [CC_W-1:0] channels;
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.sample_value = '0;
        sample_ch.restart      = 1'b0;
        result_ch.ready        = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: two channels, onset at first frame, clicks unreachable
        @(negedge clk);
        queue_sample(24'h7F_FFFF, 1'b0);
        queue_sample(24'h80_0000, 1'b0);
        queue_sample(24'h00_0000, 1'b0);
        queue_sample(24'h00_0000, 1'b0);
        queue_sample(24'h00_0001, 1'b0);
        queue_sample(24'hFF_FFFF, 1'b0);
        queue_sample(24'h00_0005, 1'b1);
        queue_sample(24'hFF_FFFA, 1'b0);
        queue_sample(24'h00_0064, 1'b0);    // left as a partial frame
        settle(4);

        // three channels with one sample already in the frame; zero click threshold
        configure(CFG_W'(3), 24'h80_0000, '0);
        @(negedge clk);
        queue_sample(24'h00_0007, 1'b0);
        queue_sample(24'hFF_FFF9, 1'b0);
        settle(4);

        // zero channel count acts as one; silence threshold beyond any magnitude
        configure(CFG_W'(0), 24'hFF_FFFF, 24'h7F_FFFF);
        @(negedge clk);
        queue_sample(24'h80_0000, 1'b0);
        queue_sample(24'h00_0000, 1'b0);
        queue_sample(24'h7F_FFFF, 1'b0);
        settle(4);

        // count above the limit saturates to eight
        configure(CFG_W'(15), 24'h00_0064, 24'h80_0000);
        @(negedge clk);
        queue_sample(24'h00_0000, 1'b1);
        queue_sample(24'h00_0001, 1'b0);
        queue_sample(24'hFF_FFFF, 1'b0);
        queue_sample(24'h00_0032, 1'b0);
        queue_sample(24'hFF_FFCE, 1'b0);
        queue_sample(24'h00_0063, 1'b0);
        queue_sample(24'hFF_FF9C, 1'b0);
        queue_sample(24'h00_0003, 1'b0);
        settle(4);

        for (int phase = 0; phase < 8; phase++)
        begin
            case ($urandom_range(0, 3))
                0: phase_level = 24'h00_00FF;
                1: phase_level = 24'h00_FFFF;
                2: phase_level = 24'h3F_FFFF;
                default: phase_level = 24'h7F_FFFF;
            endcase
            channels = ($urandom_range(0, 4) == 0) ? CC_W'($urandom_range(0, 15))
                                                   : CC_W'($urandom_range(1, MAX_CHANNELS));
            configure({(CFG_W-CC_W)'($urandom), channels},
                      draw_threshold(phase_level), draw_threshold(phase_level));
            queue_random(25, $urandom_range(0, 1));
            settle(0);  // hold the sender until the result side is empty
            queue_random(25, 1'b0);
            settle(4);
        end

        repeat (8) @(posedge clk);
        if (failures == 0 && expected_frames.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/aod_pkg.sv
hw/rtl/aod_intf.sv
hw/rtl/aod_in_stage.sv
hw/rtl/aod_core.sv
hw/rtl/audio_peak_onset_click_detector.sv
hw/rtl/aod_checker.sv
bench/audio_peak_onset_click_detector_test.sv
